>>> hdl/mpfd_pkg.sv
// Shared constants, types and address helper for the page frame store.
`default_nettype none

package mpfd_pkg;

  localparam int COLUMNS = 128;
  localparam int PAGES   = 8;
  localparam int ROWS    = PAGES * 8;
  localparam int DEPTH   = COLUMNS * PAGES;
  localparam int ADDR_W  = $clog2(DEPTH);

  typedef logic [7:0] coord_t;

  localparam coord_t   COL_LAST  = 8'(COLUMNS - 1);
  localparam coord_t   ROW_LAST  = 8'(ROWS - 1);
  localparam logic [4:0] PAGE_TOP = 5'(PAGES - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_PIXEL   = 3'd1,
    OP_FILL    = 3'd2,
    OP_OUTLINE = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  // byte index = column * PAGES + page; caller keeps both in range
  function automatic logic [ADDR_W-1:0] store_addr(input coord_t col, input logic [4:0] page);
    logic [ADDR_W+8:0] a;
    a = (ADDR_W+9)'(col) * (ADDR_W+9)'(PAGES) + (ADDR_W+9)'(page);
    return a[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/mono_page_framebuffer_draw.sv
// Top level: 128x64 page-organised frame store with clear, pixel, box and read operations.
//
//   channel   dir  transfer          payload
//   command   in   start && !busy    operation, first_x, first_y, second_x, second_y,
//                                    pixel_value
//   result    out  done (one cycle)  read_data
//
// Clear and reset both sweep the store, one byte a cycle, all DEPTH (1024) bytes, busy high.
// Pixel: setup, read, write, then the result strobe. Read byte: the RAM read, then the strobe.
// Fill and outline: a setup step per box (outline has four), then a read and a write step per byte
// touched, for the read-modify-write on the single RAM port. Unused codes answer next cycle.
// busy drops in the cycle the strobe shows; the receiver cannot stall.
`default_nettype none

module mono_page_framebuffer_draw (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      operation,
  input  mpfd_pkg::coord_t first_x,
  input  mpfd_pkg::coord_t first_y,
  input  mpfd_pkg::coord_t second_x,
  input  mpfd_pkg::coord_t second_y,
  input  logic            pixel_value,
  output logic            done,
  output logic [7:0]      read_data
);

  import mpfd_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_SETUP, S_RD, S_WR, S_READ
  } state_t;

  state_t state;
  op_t    op_q;
  coord_t fx_q, fy_q, sx_q, sy_q;
  logic   colour_q;
  logic   rd_ok;
  logic   reply_q;
  logic [1:0] phase;
  coord_t x, x_end, y_lo, y_hi;
  logic [4:0] g;
  logic [ADDR_W-1:0] sweep_cnt;

  // current box
  coord_t bx_l, bx_h, by_l, by_h, x_clip, y_clip;
  logic   box_en, box_last, box_empty, col_bit;

  logic [7:0] mask, wr_byte, ram_rdata, ram_wdata;
  logic [ADDR_W-1:0] ram_addr;
  logic ram_we;

  always_comb begin
    bx_l = fx_q;
    bx_h = fx_q;
    by_l = fy_q;
    by_h = fy_q;
    box_en = 1'b1;
    box_last = 1'b1;
    col_bit = colour_q;
    case (op_q)
      OP_FILL: begin
        bx_l = (fx_q < sx_q) ? fx_q : sx_q;
        bx_h = (fx_q < sx_q) ? sx_q : fx_q;
        by_l = (fy_q < sy_q) ? fy_q : sy_q;
        by_h = (fy_q < sy_q) ? sy_q : fy_q;
      end
      OP_OUTLINE: begin
        // two rows then two columns, each only when its corners run forwards
        col_bit = 1'b1;
        box_last = (phase == 2'd3);
        case (phase)
          2'd0: begin
            bx_h = sx_q;
            box_en = (fx_q <= sx_q);
          end
          2'd1: begin
            bx_h = sx_q;
            by_l = sy_q;
            by_h = sy_q;
            box_en = (fx_q <= sx_q);
          end
          2'd2: begin
            by_h = sy_q;
            box_en = (fy_q <= sy_q);
          end
          default: begin
            bx_l = sx_q;
            bx_h = sx_q;
            by_h = sy_q;
            box_en = (fy_q <= sy_q);
          end
        endcase
      end
      default: ;
    endcase
    x_clip = (bx_h > COL_LAST) ? COL_LAST : bx_h;
    y_clip = (by_h > ROW_LAST) ? ROW_LAST : by_h;
    box_empty = !box_en || ({1'b0, bx_l} >= 9'(COLUMNS)) || (by_l > ROW_LAST);
  end

  // rows of group g that fall in [y_lo, y_hi]; row r of a group is bit 7-r
  always_comb begin
    logic [7:0] yv;
    yv = '0;
    for (int r = 0; r < 8; r++) begin
      yv = {g, 3'(r)};
      mask[7-r] = (yv >= y_lo) && (yv <= y_hi);
    end
  end

  assign wr_byte = col_bit ? (ram_rdata | mask) : (ram_rdata & ~mask);

  always_comb begin
    ram_we = 1'b0;
    ram_addr = store_addr(x, PAGE_TOP - g);
    ram_wdata = wr_byte;
    case (state)
      S_SWEEP: begin
        ram_we = 1'b1;
        ram_addr = sweep_cnt;
        ram_wdata = '0;
      end
      S_IDLE: ram_addr = store_addr(first_x, first_y[4:0]);
      S_WR:   ram_we = 1'b1;
      default: ;
    endcase
  end

  mpfd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      sweep_cnt <= '0;
      reply_q <= 1'b0;
      phase <= '0;
      done <= 1'b0;
      read_data <= '0;
    end else begin
      done <= 1'b0;
      read_data <= '0;
      case (state)
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == ADDR_LAST) begin
            sweep_cnt <= '0;
            done <= reply_q;
            reply_q <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q <= op_t'(operation);
            fx_q <= first_x;
            fy_q <= first_y;
            sx_q <= second_x;
            sy_q <= second_y;
            colour_q <= pixel_value;
            phase <= '0;
            rd_ok <= ({1'b0, first_x} < 9'(COLUMNS)) && ({1'b0, first_y} < 9'(PAGES));
            case (operation)
              OP_CLEAR: begin
                reply_q <= 1'b1;
                state <= S_SWEEP;
              end
              OP_PIXEL, OP_FILL, OP_OUTLINE: state <= S_SETUP;
              OP_READ: state <= S_READ;
              default: done <= 1'b1;
            endcase
          end
        end
        S_SETUP: begin
          if (box_empty) begin
            if (box_last) begin
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              phase <= phase + 1'b1;
            end
          end else begin
            x <= bx_l;
            x_end <= x_clip;
            g <= by_l[7:3];
            y_lo <= by_l;
            y_hi <= y_clip;
            state <= S_RD;
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (g == y_hi[7:3]) begin
            if (x == x_end) begin
              if (box_last) begin
                done <= 1'b1;
                state <= S_IDLE;
              end else begin
                phase <= phase + 1'b1;
                state <= S_SETUP;
              end
            end else begin
              x <= x + 1'b1;
              g <= y_lo[7:3];
              state <= S_RD;
            end
          end else begin
            g <= g + 1'b1;
            state <= S_RD;
          end
        end
        S_READ: begin
          done <= 1'b1;
          read_data <= rd_ok ? ram_rdata : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_on_result: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe raised while still busy");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation != OP_PIXEL && operation != OP_FILL &&
     operation != OP_OUTLINE && operation != OP_READ && operation != OP_CLEAR) |=> done)
    else $error("unused operation code did not answer at once");

  a_data_only_on_strobe: assert property (@(posedge clk) disable iff (rst)
    (read_data != 8'd0) |-> done)
    else $error("read_data non-zero outside a result");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("frame store written while idle");

endmodule

`default_nettype wire

>>> hdl/mpfd_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none

module mpfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire
